FILE: src/cla_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cla_pkg
// Shared types and constants for the comment lane allocator.
// ----------------------------------------------------------------------------
package cla_pkg;

   localparam int DEF_MAX_LANES = 32;

   // time widths
   localparam int TIME_W = 33;
   localparam int OUT_W  = 32;

   // timing constants in milliseconds
   localparam logic [12:0] STATIC_DUR_MS  = 13'd4200;
   localparam logic [10:0] STATIC_WAIT_MS = 11'd1800;
   localparam logic [8:0]  SCROLL_WAIT_MS = 9'd300;
   localparam logic [14:0] SCROLL_MIN_MS  = 15'd2200;
   localparam logic [14:0] SCROLL_MAX_MS  = 15'd22000;

   // comment kinds
   localparam logic [1:0] KIND_SCROLL  = 2'd0;
   localparam logic [1:0] KIND_TOP     = 2'd1;
   localparam logic [1:0] KIND_BOTTOM  = 2'd2;
   localparam logic [1:0] KIND_SCROLL2 = 2'd3;

   // register indexes
   localparam logic [2:0] REG_OFFSET   = 3'd0;
   localparam logic [2:0] REG_LANES    = 3'd1;
   localparam logic [2:0] REG_HIDE     = 3'd2;
   localparam logic [2:0] REG_MSPP     = 3'd3;
   localparam logic [2:0] REG_BASEDIST = 3'd4;
   localparam logic [2:0] REG_GAPPAD   = 3'd5;

   // free times of one lane for all three kinds
   typedef struct packed {
      logic [TIME_W-1:0] scroll;
      logic [TIME_W-1:0] top;
      logic [TIME_W-1:0] bottom;
   } lane_times_type;

endpackage

FILE: src/cla_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cla_cell
// One lane of the ring: holds the free times and passes them on when shifting.
// ----------------------------------------------------------------------------
module cla_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    shift_en,
   input  cla_pkg::lane_times_type din,
   output cla_pkg::lane_times_type dout
);
   import cla_pkg::*;

   lane_times_type times_ff;
   lane_times_type times_in;

   // take the neighbour's times on a shift
   always_comb begin
      times_in = times_ff;
      if (shift_en) begin
         times_in = din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         times_ff <= '0;
      end else begin
         times_ff <= times_in;
      end
   end

   assign dout = times_ff;

endmodule

FILE: src/cla_scroll_math.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cla_scroll_math
// Scroll duration and lane gap from pixel distances and Q16 speed.
// ----------------------------------------------------------------------------
module cla_scroll_math (
   input  logic        clock,
   input  logic [13:0] width_px,
   input  logic [22:0] ms_per_pixel_q16,
   input  logic [13:0] base_distance_px,
   input  logic [9:0]  gap_padding_px,
   output logic [14:0] dur_ms,
   output logic [21:0] gap_ms
);
   import cla_pkg::*;

   logic [37:0] dur_prod_ff, dur_prod_in;
   logic [37:0] gap_prod_ff, gap_prod_in;
   logic [38:0] dur_round;
   logic [38:0] gap_round;
   logic [22:0] dur_raw;

   // distance times speed, registered
   always_comb begin
      dur_prod_in = ({1'b0, base_distance_px} + {1'b0, width_px}) * ms_per_pixel_q16;
      gap_prod_in = ({1'b0, width_px} + {5'd0, gap_padding_px}) * ms_per_pixel_q16;
   end

   always_ff @(posedge clock) begin
      dur_prod_ff <= dur_prod_in;
      gap_prod_ff <= gap_prod_in;
   end

   // rounding and clamp
   always_comb begin
      dur_round = {1'b0, dur_prod_ff} + 39'd32768;
      gap_round = {1'b0, gap_prod_ff} + 39'd65535;
      dur_raw   = dur_round[38:16];
      if (dur_raw < {8'd0, SCROLL_MIN_MS}) begin
         dur_ms = SCROLL_MIN_MS;
      end else if (dur_raw > {8'd0, SCROLL_MAX_MS}) begin
         dur_ms = SCROLL_MAX_MS;
      end else begin
         dur_ms = dur_raw[14:0];
      end
      gap_ms = gap_round[37:16];
   end

endmodule

FILE: src/comment_lane_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// comment_lane_allocator
// Places time-sorted overlay comments into per-kind display lanes.
// ----------------------------------------------------------------------------
// channel | dir | contents
// req     | in  | tdata: time_ms, width_px; tuser: kind
// rsp     | out | tdata: lane, start_ms, end_ms; tuser: accepted
// csr     | in  | write enable, register index, write data
//
// An item's lane ring rotates once to pick a lane and once more to write it
// back. Dropped items skip the write pass; hidden items go straight to the
// output.
// Reset is synchronous and clears all lanes.
// A finished item waits in the output register; the next item is taken
// meanwhile and stalls only when its own result is ready.
// ----------------------------------------------------------------------------
module comment_lane_allocator #(
   parameter int MAX_LANES = cla_pkg::DEF_MAX_LANES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // time_ms[31:0], width_px[45:32], zero pad
   input  logic [1:0]  req_tuser,  // kind[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,  // lane[4:0], start_ms[36:5], end_ms[68:37], pad
   output logic        rsp_tuser,  // accepted
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [27:0] csr_wdata
);
   import cla_pkg::*;

   localparam int IW   = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
   localparam int LW   = $clog2(MAX_LANES + 1);
   localparam int CMPW = ((LW > 6) ? LW : 6) + 1;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_WRITE  = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   // configuration registers
   logic [27:0] offset_ff;
   logic [5:0]  lanes_ff;
   logic [2:0]  hide_ff;
   logic [22:0] mspp_ff;
   logic [13:0] base_ff;
   logic [9:0]  gappad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         lanes_ff  <= 6'd1;
         hide_ff   <= '0;
         mspp_ff   <= 23'd65536;
         base_ff   <= 14'd2000;
         gappad_ff <= 10'd96;
      end else if (csr_we) begin
         case (csr_index)
            REG_OFFSET:   offset_ff <= csr_wdata;
            REG_LANES:    lanes_ff  <= csr_wdata[5:0];
            REG_HIDE:     hide_ff   <= csr_wdata[2:0];
            REG_MSPP:     mspp_ff   <= csr_wdata[22:0];
            REG_BASEDIST: base_ff   <= csr_wdata[13:0];
            REG_GAPPAD:   gappad_ff <= csr_wdata[9:0];
            default: begin
            end
         endcase
      end
   end

   // control and item registers
   logic [2:0]        state_ff, state_in;
   logic [IW-1:0]     cnt_ff, cnt_in;
   logic [1:0]        kind_ff, kind_in;
   logic [13:0]       width_ff, width_in;
   logic [TIME_W-1:0] start_ff, start_in;
   logic              found_ff, found_in;
   logic [IW-1:0]     lane_ff, lane_in;
   logic [TIME_W-1:0] best_ff, best_in;
   logic [TIME_W-1:0] next_ff, next_in;
   logic              acc_ff, acc_in;
   logic [OUT_W-1:0]  rstart_ff, rstart_in;
   logic [OUT_W-1:0]  rend_ff, rend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [71:0]       rsp_data_ff, rsp_data_in;
   logic              rsp_acc_ff, rsp_acc_in;

   // ring of lane cells
   lane_times_type    ring_q [MAX_LANES];
   lane_times_type    tail_in;
   logic              shift_en;

   genvar gi;
   generate
      for (gi = 0; gi < MAX_LANES; gi++) begin : g_cell
         if (gi == MAX_LANES - 1) begin : g_tail
            cla_cell u_cell (
               .clock    (clock),
               .reset    (reset),
               .shift_en (shift_en),
               .din      (tail_in),
               .dout     (ring_q[gi])
            );
         end else begin : g_mid
            cla_cell u_cell (
               .clock    (clock),
               .reset    (reset),
               .shift_en (shift_en),
               .din      (ring_q[gi+1]),
               .dout     (ring_q[gi])
            );
         end
      end
   endgenerate

   // scroll timing
   logic [14:0] dur_ms;
   logic [21:0] gap_ms;

   cla_scroll_math u_math (
      .clock            (clock),
      .width_px         (width_ff),
      .ms_per_pixel_q16 (mspp_ff),
      .base_distance_px (base_ff),
      .gap_padding_px   (gappad_ff),
      .dur_ms           (dur_ms),
      .gap_ms           (gap_ms)
   );

   // helpers
   logic [33:0]       sum_start;
   logic              hidden;
   logic              is_static;
   logic [TIME_W-1:0] head_t;
   logic [CMPW-1:0]   lc_eff;
   logic              in_range;
   logic              last_cnt;
   logic [TIME_W-1:0] actual;
   logic [TIME_W-1:0] wait_t;
   logic [19:0]       wait_lim;
   logic [20:0]       wait_x100;
   logic              drop;
   logic [33:0]       end_sum;
   logic [33:0]       next_sum;

   assign req_tready = (state_ff == ST_IDLE);
   assign is_static  = (kind_ff == KIND_TOP) || (kind_ff == KIND_BOTTOM);
   assign last_cnt   = (cnt_ff == IW'(MAX_LANES - 1));
   assign shift_en   = (state_ff == ST_SCAN) || (state_ff == ST_WRITE);

   always_comb begin
      // requested start and hide check
      sum_start = {2'b00, req_tdata[31:0]} + {{6{offset_ff[27]}}, offset_ff};
      hidden = ((req_tuser == KIND_SCROLL) && hide_ff[0]) ||
               ((req_tuser == KIND_TOP) && hide_ff[1]) ||
               ((req_tuser == KIND_BOTTOM) && hide_ff[2]);

      // head lane time of this kind
      case (kind_ff)
         KIND_TOP:    head_t = ring_q[0].top;
         KIND_BOTTOM: head_t = ring_q[0].bottom;
         default:     head_t = ring_q[0].scroll;
      endcase

      // active lane count, clamped to 1..MAX_LANES
      if (lanes_ff == 6'd0) begin
         lc_eff = CMPW'(1);
      end else if (CMPW'(lanes_ff) > CMPW'(MAX_LANES)) begin
         lc_eff = CMPW'(MAX_LANES);
      end else begin
         lc_eff = CMPW'(lanes_ff);
      end
      in_range = CMPW'(cnt_ff) < lc_eff;

      // wait and drop decision
      actual    = (best_ff > start_ff) ? best_ff : start_ff;
      wait_t    = actual - start_ff;
      wait_lim  = 20'(dur_ms * 6'd42) + 20'd50;
      wait_x100 = 21'(wait_t[13:0] * 7'd100);
      if (is_static) begin
         drop = wait_t > TIME_W'(STATIC_WAIT_MS);
      end else begin
         drop = (wait_t > TIME_W'(SCROLL_WAIT_MS)) &&
                ((|wait_t[TIME_W-1:14]) || (wait_x100 > {1'b0, wait_lim}));
      end
      if (is_static) begin
         end_sum  = {1'b0, actual} + 34'(STATIC_DUR_MS);
         next_sum = end_sum;
      end else begin
         end_sum  = {1'b0, actual} + 34'(dur_ms);
         next_sum = {1'b0, actual} + 34'(gap_ms);
      end
   end

   // tail feed: pass through, or the new free time on the write pass
   always_comb begin
      tail_in = ring_q[0];
      if ((state_ff == ST_WRITE) && (cnt_ff == lane_ff)) begin
         case (kind_ff)
            KIND_TOP:    tail_in.top    = next_ff;
            KIND_BOTTOM: tail_in.bottom = next_ff;
            default:     tail_in.scroll = next_ff;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      kind_in      = kind_ff;
      width_in     = width_ff;
      start_in     = start_ff;
      found_in     = found_ff;
      lane_in      = lane_ff;
      best_in      = best_ff;
      next_in      = next_ff;
      acc_in       = acc_ff;
      rstart_in    = rstart_ff;
      rend_in      = rend_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_acc_in   = rsp_acc_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               kind_in   = req_tuser;
               width_in  = req_tdata[45:32];
               start_in  = sum_start[33] ? '0 : sum_start[32:0];
               cnt_in    = '0;
               acc_in    = 1'b0;
               rstart_in = '0;
               rend_in   = '0;
               lane_in   = '0;
               state_in  = hidden ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cnt_ff == '0) begin
               best_in  = head_t;
               lane_in  = '0;
               found_in = head_t <= start_ff;
            end else if (in_range && !found_ff) begin
               if (head_t <= start_ff) begin
                  found_in = 1'b1;
                  best_in  = head_t;
                  lane_in  = cnt_ff;
               end else if (head_t < best_ff) begin
                  best_in = head_t;
                  lane_in = cnt_ff;
               end
            end
            cnt_in = cnt_ff + 1'b1;
            if (last_cnt) begin
               cnt_in   = '0;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (drop) begin
               lane_in  = '0;
               state_in = ST_DONE;
            end else begin
               acc_in    = 1'b1;
               next_in   = next_sum[33] ? {TIME_W{1'b1}} : next_sum[32:0];
               rstart_in = actual[32] ? {OUT_W{1'b1}} : actual[31:0];
               rend_in   = (|end_sum[33:32]) ? {OUT_W{1'b1}} : end_sum[31:0];
               cnt_in    = '0;
               state_in  = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cnt_in = cnt_ff + 1'b1;
            if (last_cnt) begin
               cnt_in   = '0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in   = acc_ff;
               rsp_data_in  = {3'd0, rend_ff, rstart_ff, 5'(lane_ff)};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         found_ff     <= 1'b0;
         acc_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         found_ff     <= found_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // item payload
   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      width_ff    <= width_in;
      start_ff    <= start_in;
      lane_ff     <= lane_in;
      best_ff     <= best_in;
      next_ff     <= next_in;
      rstart_ff   <= rstart_in;
      rend_ff     <= rend_in;
      rsp_data_ff <= rsp_data_in;
      rsp_acc_ff  <= rsp_acc_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_acc_ff;

`ifndef SYNTH
   // an accepted item always leaves idle
   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff != ST_IDLE))
      else $error("item accepted but sequencer stayed idle");

   // a rejected item carries all-zero fields
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("rejected item with non-zero fields");

   // a drop never reaches the write pass
   a_drop_nowrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE && drop) |=> (state_ff == ST_DONE))
      else $error("dropped item entered write pass");

   // the write pass only runs for a placed item
   a_write_acc: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |-> acc_ff)
      else $error("lane write without placement");
`endif

endmodule
